### rtl/ray_ground_point_classifier_core_assert.svh
// Assertion macros for the ray ground point classifier.
`ifndef RAY_GROUND_POINT_CLASSIFIER_CORE_ASSERT_SVH
`define RAY_GROUND_POINT_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication.
`define RGPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgpc assertion failed");

// Next-cycle implication.
`define RGPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgpc assertion failed");

`endif

### rtl/rgpc_pkg.sv
package rgpc_pkg;

   localparam int unsigned RadiusWidth   = 18;
   localparam int unsigned HeightWidth   = 16;
   localparam int unsigned SensorWidth   = 13;
   localparam int unsigned TanWidth      = 16;
   localparam int unsigned MinHeightWidth = 10;
   localparam int unsigned ConcDistWidth = 14;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SENSOR_HEIGHT  = 3'd0,
      CSR_LOCAL_SLOPE    = 3'd1,
      CSR_GENERAL_SLOPE  = 3'd2,
      CSR_MIN_LOCAL_HGT  = 3'd3,
      CSR_CONCENTRIC     = 3'd4
   } csr_index_type;

   localparam logic [SensorWidth-1:0]    SensorHeightReset = 13'd360;
   localparam logic [TanWidth-1:0]       LocalSlopeReset   = 16'd3435;
   localparam logic [TanWidth-1:0]       GeneralSlopeReset = 16'd2289;
   localparam logic [MinHeightWidth-1:0] MinLocalReset     = 10'd50;
   localparam logic [ConcDistWidth-1:0]  ConcentricReset   = 14'd100;

endpackage

### rtl/ray_ground_point_classifier_core.sv
// Classifies lidar points, streamed ray by ray in order of radius, as ground or not. One point
// is accepted every cycle unless req_stall is high; it passes through one input register and
// one result register. A stalled result holds the pipeline and raises req_stall once the
// input register is also full.
// Throughput is set by the per-point state loop: the previous point's radius, height and ground
// flag feed the local Q0.16 slope multiply and the threshold compares of the next point.
// Registers are written through the csr port, which is always ready; write them only
// while no point is in flight. Register indexes above four are ignored.
module ray_ground_point_classifier_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [rgpc_pkg::RadiusWidth-1:0]       req_radius_mm,
   input  logic signed [rgpc_pkg::HeightWidth-1:0] req_height_mm,
   input  logic                                   req_ray_start,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_is_ground,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rgpc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [rgpc_pkg::CsrDataWidth-1:0]      csr_wdata
);

   // configuration
   logic [rgpc_pkg::SensorWidth-1:0]    sensor_height_ff;
   logic [rgpc_pkg::TanWidth-1:0]       local_tan_ff;
   logic [rgpc_pkg::TanWidth-1:0]       general_tan_ff;
   logic [rgpc_pkg::MinHeightWidth-1:0] min_local_ff;
   logic [rgpc_pkg::ConcDistWidth-1:0]  conc_dist_ff;

   // input stage
   logic                                    s1_valid_ff;
   logic [rgpc_pkg::RadiusWidth-1:0]        s1_radius_ff;
   logic signed [rgpc_pkg::HeightWidth-1:0] s1_height_ff;
   logic                                    s1_start_ff;

   // per-ray state
   logic [rgpc_pkg::RadiusWidth-1:0]  last_radius_ff;
   logic signed [16:0]                last_height_ff;
   logic                              last_ground_ff;

   // result
   logic rsp_valid_ff;
   logic rsp_ground_ff;

   logic advance;
   logic req_accept;

   logic [rgpc_pkg::RadiusWidth-1:0] base_radius;
   logic signed [16:0]               base_height;
   logic                             base_ground;
   logic signed [16:0]               neg_sensor;

   logic signed [18:0] step;
   logic signed [35:0] local_prod;
   logic signed [35:0] floor_thr;
   logic signed [35:0] local_thr;
   logic signed [17:0] hdiff;
   logic signed [35:0] hdiff_q;
   logic               local_ok;

   logic [33:0]        general_prod;
   logic signed [35:0] general_thr;
   logic signed [17:0] gdiff;
   logic signed [35:0] gdiff_q;
   logic               general_ok;

   logic ground_in;

   assign csr_ready  = 1'b1;
   assign advance    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_ground = rsp_ground_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_height_ff <= rgpc_pkg::SensorHeightReset;
         local_tan_ff     <= rgpc_pkg::LocalSlopeReset;
         general_tan_ff   <= rgpc_pkg::GeneralSlopeReset;
         min_local_ff     <= rgpc_pkg::MinLocalReset;
         conc_dist_ff     <= rgpc_pkg::ConcentricReset;
      end else if (csr_valid && csr_ready) begin
         case (rgpc_pkg::csr_index_type'(csr_index))
            rgpc_pkg::CSR_SENSOR_HEIGHT: begin
               sensor_height_ff <= csr_wdata[rgpc_pkg::SensorWidth-1:0];
            end
            rgpc_pkg::CSR_LOCAL_SLOPE: begin
               local_tan_ff <= csr_wdata[rgpc_pkg::TanWidth-1:0];
            end
            rgpc_pkg::CSR_GENERAL_SLOPE: begin
               general_tan_ff <= csr_wdata[rgpc_pkg::TanWidth-1:0];
            end
            rgpc_pkg::CSR_MIN_LOCAL_HGT: begin
               min_local_ff <= csr_wdata[rgpc_pkg::MinHeightWidth-1:0];
            end
            rgpc_pkg::CSR_CONCENTRIC: begin
               conc_dist_ff <= csr_wdata[rgpc_pkg::ConcDistWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ray start replaces the carried state before the point is judged
   always_comb begin
      neg_sensor  = -$signed({4'b0, sensor_height_ff});
      base_radius = s1_start_ff ? '0 : last_radius_ff;
      base_height = s1_start_ff ? neg_sensor : last_height_ff;
      base_ground = s1_start_ff ? 1'b0 : last_ground_ff;

      // all thresholds compared in units of 2^-16 mm
      step       = $signed({1'b0, s1_radius_ff}) - $signed({1'b0, base_radius});
      local_prod = $signed({1'b0, local_tan_ff}) * step;
      floor_thr  = $signed({10'b0, min_local_ff, 16'b0});
      if ((s1_radius_ff > {4'b0, conc_dist_ff}) && (local_prod < floor_thr)) begin
         local_thr = floor_thr;
      end else begin
         local_thr = local_prod;
      end
      hdiff    = {{2{s1_height_ff[15]}}, s1_height_ff} - {base_height[16], base_height};
      hdiff_q  = {{2{hdiff[17]}}, hdiff, 16'b0};
      local_ok = (hdiff_q <= local_thr) && (hdiff_q >= -local_thr);

      general_prod = general_tan_ff * s1_radius_ff;
      general_thr  = $signed({2'b0, general_prod});
      gdiff        = {{2{s1_height_ff[15]}}, s1_height_ff} + $signed({5'b0, sensor_height_ff});
      gdiff_q      = {{2{gdiff[17]}}, gdiff, 16'b0};
      general_ok   = (gdiff_q <= general_thr) && (gdiff_q >= -general_thr);

      ground_in = local_ok && (base_ground || general_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_radius_ff <= '0;
         last_height_ff <= -$signed({4'b0, rgpc_pkg::SensorHeightReset});
         last_ground_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            last_radius_ff <= s1_radius_ff;
            last_height_ff <= {s1_height_ff[15], s1_height_ff};
            last_ground_ff <= ground_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_radius_ff <= req_radius_mm;
         s1_height_ff <= req_height_mm;
         s1_start_ff  <= req_ray_start;
      end
      if (advance) begin
         rsp_ground_ff <= ground_in;
      end
   end

`include "ray_ground_point_classifier_core_assert.svh"

   // accepted point lands in the input stage
   `RGPC_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_accept, s1_valid_ff)

   // state follows the point that moved to the result register
   `RGPC_ASSERT_NEXT(a_state_tracks_result, clock, reset, advance,
      (last_radius_ff == $past(s1_radius_ff)) && (last_ground_ff == rsp_ground_ff))

   // a pending ground result always matches the carried ground flag
   `RGPC_ASSERT_NOW(a_ground_matches_state, clock, reset, rsp_valid_ff,
      rsp_ground_ff == last_ground_ff)

endmodule

### tb/ray_ground_point_classifier_core_tb.sv
`timescale 1ns / 100ps

module ray_ground_point_classifier_core_tb;

   localparam longint FracOne = 65536;
   localparam int unsigned CsrIndexCount = 1 << rgpc_pkg::CsrIndexWidth;
   localparam int RadiusTop = (1 << rgpc_pkg::RadiusWidth) - 1;
   localparam int HeightMin = -(1 << (rgpc_pkg::HeightWidth - 1));
   localparam int HeightMax = (1 << (rgpc_pkg::HeightWidth - 1)) - 1;
   localparam int unsigned RandomPoints = 1300;
   localparam int unsigned RandomPhases = 6;
   localparam int unsigned SettleCycles = 4;
   localparam longint CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [rgpc_pkg::RadiusWidth-1:0] req_radius_mm = '0;
   logic signed [rgpc_pkg::HeightWidth-1:0] req_height_mm = '0;
   logic req_ray_start = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_is_ground;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rgpc_pkg::CsrIndexWidth-1:0] csr_index = rgpc_pkg::CSR_SENSOR_HEIGHT;
   logic [rgpc_pkg::CsrDataWidth-1:0] csr_wdata = '0;

   // register mirror
   logic [rgpc_pkg::SensorWidth-1:0] cfg_sensor_height = rgpc_pkg::SensorHeightReset;
   logic [rgpc_pkg::TanWidth-1:0] cfg_local_tan = rgpc_pkg::LocalSlopeReset;
   logic [rgpc_pkg::TanWidth-1:0] cfg_general_tan = rgpc_pkg::GeneralSlopeReset;
   logic [rgpc_pkg::MinHeightWidth-1:0] cfg_min_height = rgpc_pkg::MinLocalReset;
   logic [rgpc_pkg::ConcDistWidth-1:0] cfg_concentric = rgpc_pkg::ConcentricReset;

   // classifier state as tracked by the testbench
   logic [rgpc_pkg::RadiusWidth-1:0] last_radius_q = '0;
   int last_height_q = -int'(rgpc_pkg::SensorHeightReset);
   bit last_ground_q = 1'b0;

   bit ground_expect_q[$];
   bit idling_on = 1'b1;
   int unsigned points_sent = 0;
   int unsigned results_checked = 0;
   int unsigned ground_seen = 0;
   int unsigned csr_writes = 0;
   int unsigned error_count = 0;
   longint cycle_count = 0;

   ray_ground_point_classifier_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_radius_mm (req_radius_mm),
      .req_height_mm (req_height_mm),
      .req_ray_start (req_ray_start),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_ground (rsp_is_ground),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout at cycle %0d with %0d results outstanding", cycle_count,
                  ground_expect_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Exact Q0.16 comparisons in units of 2^-16 mm; updates the tracked state.
   function automatic bit classify_point(input logic [rgpc_pkg::RadiusWidth-1:0] radius,
                                         input logic signed [rgpc_pkg::HeightWidth-1:0] height,
                                         input logic ray_start);
      longint step_len, local_thr, general_thr, floor_thr;
      longint height_fix, prev_fix, ground_fix;
      bit local_ok, general_ok, ground;
      if (ray_start) begin
         last_radius_q = '0;
         last_height_q = -int'(cfg_sensor_height);
         last_ground_q = 1'b0;
      end
      step_len = longint'(radius) - longint'(last_radius_q);
      local_thr = longint'(cfg_local_tan) * step_len;
      general_thr = longint'(cfg_general_tan) * longint'(radius);
      floor_thr = longint'(cfg_min_height) * FracOne;
      // floor only strictly beyond the concentric distance
      if (radius > cfg_concentric && local_thr < floor_thr)
         local_thr = floor_thr;
      height_fix = longint'(height) * FracOne;
      prev_fix = longint'(last_height_q) * FracOne;
      ground_fix = -longint'(cfg_sensor_height) * FracOne;
      local_ok = height_fix <= prev_fix + local_thr && height_fix >= prev_fix - local_thr;
      general_ok = height_fix <= ground_fix + general_thr
                   && height_fix >= ground_fix - general_thr;
      ground = local_ok && (last_ground_q || general_ok);
      last_ground_q = ground;
      last_radius_q = radius;
      last_height_q = height;
      return ground;
   endfunction

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("[%0d] %s", cycle_count, msg);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!idling_on)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result checker and expectation tracking
   always @(posedge clock) begin
      bit want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (ground_expect_q.size() == 0) begin
               note_error($sformatf("result with nothing expected: is_ground=%0b",
                                    rsp_is_ground));
            end else begin
               want = ground_expect_q.pop_front();
               if (rsp_is_ground !== want)
                  note_error($sformatf("result %0d: is_ground expected %0b, got %0b",
                                       results_checked, want, rsp_is_ground));
               results_checked++;
               if (rsp_is_ground === 1'b1)
                  ground_seen++;
            end
         end
         if (req_valid && !req_stall)
            ground_expect_q.insert(ground_expect_q.size(),
                                   classify_point(req_radius_mm, req_height_mm,
                                                  req_ray_start));
      end
   end

   // downstream back-pressure
   initial begin
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (pick_gap() + 1) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_point(input int radius, input int height, input logic ray_start);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_radius_mm <= radius[rgpc_pkg::RadiusWidth-1:0];
      req_height_mm <= height[rgpc_pkg::HeightWidth-1:0];
      req_ray_start <= ray_start;
      do @(posedge clock); while (!(req_valid && !req_stall));
      points_sent++;
   endtask

   // Stop sending and wait until every outstanding point has been answered.
   task automatic drain_points();
      req_valid <= 1'b0;
      do @(posedge clock); while (ground_expect_q.size() != 0);
   endtask

   // Leaves csr_valid high so back-to-back writes need no re-raise.
   task automatic write_reg(input logic [rgpc_pkg::CsrIndexWidth-1:0] index,
                            input int data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data[rgpc_pkg::CsrDataWidth-1:0];
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (index)
         rgpc_pkg::CSR_SENSOR_HEIGHT: cfg_sensor_height = data[rgpc_pkg::SensorWidth-1:0];
         rgpc_pkg::CSR_LOCAL_SLOPE:   cfg_local_tan = data[rgpc_pkg::TanWidth-1:0];
         rgpc_pkg::CSR_GENERAL_SLOPE: cfg_general_tan = data[rgpc_pkg::TanWidth-1:0];
         rgpc_pkg::CSR_MIN_LOCAL_HGT: cfg_min_height = data[rgpc_pkg::MinHeightWidth-1:0];
         rgpc_pkg::CSR_CONCENTRIC:    cfg_concentric = data[rgpc_pkg::ConcDistWidth-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_config(input int mount_mm, input int local_tan, input int general_tan,
                             input int min_height, input int concentric);
      drain_points();
      write_reg(rgpc_pkg::CSR_SENSOR_HEIGHT, mount_mm);
      write_reg(rgpc_pkg::CSR_LOCAL_SLOPE, local_tan);
      write_reg(rgpc_pkg::CSR_GENERAL_SLOPE, general_tan);
      write_reg(rgpc_pkg::CSR_MIN_LOCAL_HGT, min_height);
      write_reg(rgpc_pkg::CSR_CONCENTRIC, concentric);
      csr_valid <= 1'b0;
   endtask

   // Mostly a well-formed outward ray along the ground, with obstacles and junk mixed in.
   task automatic send_ray(input int unsigned points);
      int radius, height, level, roll;
      bit start;
      radius = $urandom_range(0, 2000);
      level = -int'(cfg_sensor_height);
      height = level;
      for (int unsigned i = 0; i < points; i++) begin
         roll = $urandom_range(0, 99);
         start = (i == 0) ? ($urandom_range(0, 19) != 0) : (roll == 99);
         if (roll < 80) begin
            radius += (roll < 3) ? $urandom_range(0, 60000) : $urandom_range(0, 300);
            height += int'($urandom_range(0, 40)) - 20;
            if (height > level + 200 || height < level - 200)
               height = level;
         end else if (roll < 90) begin
            radius += $urandom_range(0, 300);
            height = level + int'($urandom_range(60, 2000));
         end else if (roll < 95) begin
            radius -= $urandom_range(0, 500);
         end else begin
            radius = $urandom_range(0, RadiusTop);
            height = int'($urandom_range(0, HeightMax - HeightMin)) + HeightMin;
         end
         if (radius < 0 || radius > RadiusTop)
            radius = $urandom_range(0, 2000);
         send_point(radius, height, start);
      end
   endtask

   task automatic test_reset_state();
      // first points rely on the post-reset state, no ray start
      send_point(0, -360, 1'b0);
      send_point(50, -358, 1'b0);
      send_point(150, -300, 1'b0);
      send_point(200, -355, 1'b1);
   endtask

   task automatic test_field_extremes();
      send_point(0, HeightMin, 1'b1);
      send_point(RadiusTop, HeightMax, 1'b0);
      send_point(RadiusTop, HeightMax, 1'b1);
      send_point(0, -360, 1'b0);
      // concentric boundary: no floor at equality, floor one past it
      send_point(int'(rgpc_pkg::ConcentricReset), -356, 1'b1);
      send_point(int'(rgpc_pkg::ConcentricReset) + 1, -320, 1'b0);
      // radius going backwards
      send_point(500, -360, 1'b0);
      send_point(400, -355, 1'b0);
   endtask

   task automatic test_sensor_height_change();
      send_point(300, -360, 1'b1);
      send_point(320, -359, 1'b0);
      drain_points();
      write_reg(rgpc_pkg::CSR_SENSOR_HEIGHT, 1000);
      csr_valid <= 1'b0;
      // ray continues with the old previous height
      send_point(340, -358, 1'b0);
      send_point(360, -1000, 1'b0);
      send_point(380, -1000, 1'b1);
   endtask

   task automatic test_register_extremes();
      set_config(0, 0, 0, 0, 0);
      send_point(0, 0, 1'b1);
      send_point(5, 0, 1'b0);
      send_point(3, 1, 1'b0);
      set_config(8000, 65535, 65535, 1000, 10000);
      send_point(9000, -7000, 1'b1);
      send_point(10001, -7500, 1'b0);
      // bits above each register width are dropped
      set_config(-1, -1, -1, -1, -1);
      send_point(20000, -8191, 1'b1);
      drain_points();
      for (int unsigned idx = rgpc_pkg::CSR_CONCENTRIC + 1; idx < CsrIndexCount; idx++)
         write_reg(idx[rgpc_pkg::CsrIndexWidth-1:0], int'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
      send_point(20100, -8000, 1'b0);
   endtask

   task automatic test_random_rays();
      int unsigned goal;
      for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
         case (phase)
            0: set_config(int'(rgpc_pkg::SensorHeightReset), int'(rgpc_pkg::LocalSlopeReset),
                          int'(rgpc_pkg::GeneralSlopeReset), int'(rgpc_pkg::MinLocalReset),
                          int'(rgpc_pkg::ConcentricReset));
            1: set_config(8000, 65535, 65535, 1000, 10000);
            2: set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
            default: set_config($urandom_range(100, 3000), $urandom_range(0, 20000),
                                $urandom_range(0, 10000), $urandom_range(0, 300),
                                $urandom_range(0, 5000));
         endcase
         goal = points_sent + RandomPoints / RandomPhases;
         while (points_sent < goal) begin
            idling_on = ($urandom_range(0, 4) != 0);
            send_ray($urandom_range(1, 40));
         end
         idling_on = 1'b1;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_field_extremes();
      test_sensor_height_change();
      test_register_extremes();
      test_random_rays();
      drain_points();
      repeat (SettleCycles) @(posedge clock);
      $display("classified %0d points (%0d ground) over %0d register writes",
               results_checked, ground_seen, csr_writes);
      $display("random rays across %0d settings, incl. reset values and extremes",
               RandomPhases);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
